### src/mcppt_pkg.sv
package mcppt_pkg;

    localparam int CHANNELS    = 4;
    localparam int TICK_BITS   = 16;
    localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAX_RESULTS = 4;
    localparam int NRES_BITS   = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_BITS = 1;

    localparam logic [32:0] TICK_MAX = (33'd1 << TICK_BITS) - 33'd1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_INTERVAL = 1'd1;

    // input operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DRIVE     = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED  = 2'd1;
    localparam logic [1:0] KIND_REJECTED  = 2'd2;
    localparam logic [1:0] KIND_STOP_DONE = 2'd3;

    typedef logic [TICK_BITS-1:0] t_ticks;
    typedef logic [CH_BITS-1:0]   t_ch_idx;

    typedef enum logic [1:0] {
        IV_IDLE  = 2'd0,
        IV_A     = 2'd1,
        IV_B     = 2'd2,
        IV_PAUSE = 2'd3
    } t_ival;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } t_cmd_op;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_SCAN  = 2'd1,
        BK_FLUSH = 2'd2
    } t_back_state;

    typedef struct packed {
        logic       power_after_a;
        logic       run_forever;
        logic       pause_enabled;
        logic       b_enabled;
    } t_mode;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  channel;
        logic [15:0] interval_a_ticks;
        logic [15:0] interval_b_ticks;
        logic [15:0] interval_pause_ticks;
        logic        b_enabled;
        logic        pause_enabled;
        logic        run_forever;
        logic        power_after_a;
        logic [15:0] cycle_count;
        logic [7:0]  seq_steps;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] out_channel;
        logic       powered;
        logic       last;
    } t_out;

    // classified command between front and back
    typedef struct packed {
        t_cmd_op     op;
        logic [1:0]  channel;
        logic        ok;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] p;
        t_mode       mode;
        logic [15:0] cyc;
        logic [7:0]  seq_len;
    } t_cmd;

    // per-channel working state, apart from the active interval
    typedef struct packed {
        t_ticks      rem;
        logic [15:0] cyc;
        logic [7:0]  steps;
        t_mode       mode;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] p;
        logic [7:0]  seq_len;
    } t_chan;

    function automatic t_ticks sat_ticks(input logic [15:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > TICK_MAX) begin
            w = TICK_MAX;
        end
        return TICK_BITS'(w);
    endfunction

endpackage

### src/mcppt_front.sv
module mcppt_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mcppt_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [15:0]                            i_cfg_data,
    input  logic                                   i_in_valid,
    input  mcppt_pkg::t_in                         i_in_data,
    output logic                                   o_in_ready,
    input  logic                                   i_q_full,
    output logic                                   o_push,
    output mcppt_pkg::t_cmd                        o_cmd
);

    logic [15:0] r_min_ticks;
    logic [15:0] r_max_ticks;
    logic        in_range;
    logic        start_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ticks <= 16'd1;
            r_max_ticks <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mcppt_pkg::CFG_MIN_INTERVAL: r_min_ticks <= i_cfg_data;
                mcppt_pkg::CFG_MAX_INTERVAL: r_max_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !i_q_full;
    assign in_range   = 32'(i_in_data.channel) < mcppt_pkg::CHANNELS;

    // validate the start parameters
    always_comb begin
        start_ok = in_range;
        if (i_in_data.interval_a_ticks > r_max_ticks) start_ok = 1'b0;
        if (i_in_data.b_enabled && (i_in_data.interval_b_ticks > r_max_ticks)) start_ok = 1'b0;
        if (i_in_data.pause_enabled && (i_in_data.interval_pause_ticks > r_max_ticks)) begin
            start_ok = 1'b0;
        end
        if (!i_in_data.run_forever && (i_in_data.cycle_count == 16'd0)) start_ok = 1'b0;
        if (i_in_data.pause_enabled && (i_in_data.seq_steps == 8'd0)) start_ok = 1'b0;
    end

    // classify the beat and clamp enabled intervals
    always_comb begin
        o_push       = 1'b0;
        o_cmd.op     = mcppt_pkg::CMD_TICK;
        o_cmd.ok     = 1'b0;
        o_cmd.channel = i_in_data.channel;
        o_cmd.a      = i_in_data.interval_a_ticks;
        o_cmd.b      = i_in_data.interval_b_ticks;
        o_cmd.p      = i_in_data.interval_pause_ticks;
        o_cmd.mode.b_enabled     = i_in_data.b_enabled;
        o_cmd.mode.pause_enabled = i_in_data.pause_enabled;
        o_cmd.mode.run_forever   = i_in_data.run_forever;
        o_cmd.mode.power_after_a = i_in_data.power_after_a;
        o_cmd.cyc     = i_in_data.cycle_count;
        o_cmd.seq_len = i_in_data.seq_steps;
        if (i_in_data.interval_a_ticks < r_min_ticks) o_cmd.a = r_min_ticks;
        if (i_in_data.b_enabled && (i_in_data.interval_b_ticks < r_min_ticks)) o_cmd.b = r_min_ticks;
        if (i_in_data.pause_enabled && (i_in_data.interval_pause_ticks < r_min_ticks)) begin
            o_cmd.p = r_min_ticks;
        end
        case (i_in_data.operation)
            mcppt_pkg::OP_TICK: begin
                o_cmd.op = mcppt_pkg::CMD_TICK;
                o_push   = i_in_valid && !i_q_full;
            end
            mcppt_pkg::OP_START: begin
                o_cmd.op = mcppt_pkg::CMD_START;
                o_cmd.ok = start_ok;
                o_push   = i_in_valid && !i_q_full;
            end
            mcppt_pkg::OP_STOP: begin
                o_cmd.op = mcppt_pkg::CMD_STOP;
                o_cmd.ok = in_range;
                o_push   = i_in_valid && !i_q_full;
            end
            default: begin
                // unknown operation: take the beat, queue nothing
                o_push = 1'b0;
            end
        endcase
    end

endmodule

### src/mcppt_queue.sv
module mcppt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mcppt_pkg::t_cmd i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output mcppt_pkg::t_cmd o_cmd,
    input  logic            i_pop
);

    mcppt_pkg::t_cmd                    r_mem [mcppt_pkg::QUEUE_DEPTH];
    logic [mcppt_pkg::QPTR_BITS-1:0]    r_wr_ptr;
    logic [mcppt_pkg::QPTR_BITS-1:0]    r_rd_ptr;
    logic [mcppt_pkg::QCNT_BITS-1:0]    r_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = r_count == mcppt_pkg::QCNT_BITS'(mcppt_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                if (r_wr_ptr == mcppt_pkg::QPTR_BITS'(mcppt_pkg::QUEUE_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + mcppt_pkg::QPTR_BITS'(1);
                end
            end
            if (do_pop) begin
                if (r_rd_ptr == mcppt_pkg::QPTR_BITS'(mcppt_pkg::QUEUE_DEPTH - 1)) begin
                    r_rd_ptr <= '0;
                end else begin
                    r_rd_ptr <= r_rd_ptr + mcppt_pkg::QPTR_BITS'(1);
                end
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + mcppt_pkg::QCNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - mcppt_pkg::QCNT_BITS'(1);
            end
        end
    end

endmodule

### src/mcppt_back.sv
module mcppt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  mcppt_pkg::t_cmd i_cmd,
    output logic            o_cmd_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mcppt_pkg::t_out o_out_data
);

    mcppt_pkg::t_back_state             r_state, n_state;
    mcppt_pkg::t_ch_idx                 r_scan, n_scan;
    mcppt_pkg::t_ival                   r_iv [mcppt_pkg::CHANNELS];
    mcppt_pkg::t_chan                   r_chan [mcppt_pkg::CHANNELS];
    logic                               r_hold_valid, n_hold_valid;
    logic [1:0]                         r_hold_ch, n_hold_ch;
    logic                               r_hold_pw, n_hold_pw;
    logic [mcppt_pkg::NRES_BITS-1:0]    r_nres, n_nres;
    logic                               r_out_valid;
    mcppt_pkg::t_out                    r_out;

    logic                   out_free;
    logic                   out_load;
    mcppt_pkg::t_out        out_val;
    logic                   wr_iv_en;
    logic                   wr_chan_en;
    mcppt_pkg::t_ch_idx     wr_idx;
    mcppt_pkg::t_ival       wr_iv;
    mcppt_pkg::t_chan       wr_chan;
    mcppt_pkg::t_ch_idx     cmd_idx;

    mcppt_pkg::t_ival       sc_iv;
    mcppt_pkg::t_chan       sc_chan;
    mcppt_pkg::t_ival       tk_iv;
    mcppt_pkg::t_chan       tk_chan;
    logic                   tk_res;
    logic                   tk_pw;
    logic                   counted_out;
    logic                   keep;
    logic                   need_out;
    logic                   step;
    logic                   scan_last;

    assign out_free  = !r_out_valid || i_out_ready;
    assign cmd_idx   = mcppt_pkg::CH_BITS'(i_cmd.channel);
    assign sc_iv     = r_iv[r_scan];
    assign sc_chan   = r_chan[r_scan];
    assign scan_last = r_scan == mcppt_pkg::CH_BITS'(mcppt_pkg::CHANNELS - 1);
    assign counted_out = !sc_chan.mode.run_forever && (sc_chan.cyc == 16'd0);
    assign keep      = tk_res && (r_nres < mcppt_pkg::NRES_BITS'(mcppt_pkg::MAX_RESULTS));
    assign need_out  = keep && r_hold_valid;
    assign step      = !need_out || out_free;

    // one tick on the scanned channel: count down or handle the expiry
    always_comb begin
        tk_iv   = sc_iv;
        tk_chan = sc_chan;
        tk_res  = 1'b0;
        tk_pw   = 1'b0;
        if (sc_iv != mcppt_pkg::IV_IDLE) begin
            if (sc_chan.rem > mcppt_pkg::TICK_BITS'(1)) begin
                tk_chan.rem = sc_chan.rem - mcppt_pkg::TICK_BITS'(1);
            end else begin
                case (sc_iv)
                    mcppt_pkg::IV_A: begin
                        tk_res = 1'b1;
                        tk_pw  = sc_chan.mode.power_after_a;
                        if (sc_chan.mode.b_enabled) begin
                            tk_iv       = mcppt_pkg::IV_B;
                            tk_chan.rem = mcppt_pkg::sat_ticks(sc_chan.b);
                        end else begin
                            tk_iv = mcppt_pkg::IV_IDLE;
                        end
                    end
                    mcppt_pkg::IV_B: begin
                        if (sc_chan.mode.b_enabled && !sc_chan.mode.pause_enabled) begin
                            tk_res = 1'b1;
                            if (counted_out) begin
                                tk_iv = mcppt_pkg::IV_IDLE;
                            end else begin
                                tk_pw       = !sc_chan.mode.power_after_a;
                                tk_chan.cyc = sc_chan.cyc - 16'd1;
                                tk_iv       = mcppt_pkg::IV_A;
                                tk_chan.rem = mcppt_pkg::sat_ticks(sc_chan.a);
                            end
                        end else if (sc_chan.mode.b_enabled) begin
                            if (sc_chan.steps == 8'd0) begin
                                tk_iv       = mcppt_pkg::IV_PAUSE;
                                tk_chan.rem = mcppt_pkg::sat_ticks(sc_chan.p);
                            end else begin
                                tk_res        = 1'b1;
                                tk_pw         = !sc_chan.mode.power_after_a;
                                tk_chan.steps = sc_chan.steps - 8'd1;
                                tk_iv         = mcppt_pkg::IV_A;
                                tk_chan.rem   = mcppt_pkg::sat_ticks(sc_chan.a);
                            end
                        end else begin
                            tk_iv = mcppt_pkg::IV_IDLE;
                        end
                    end
                    mcppt_pkg::IV_PAUSE: begin
                        if (counted_out) begin
                            tk_iv = mcppt_pkg::IV_IDLE;
                        end else begin
                            tk_res        = 1'b1;
                            tk_pw         = !sc_chan.mode.power_after_a;
                            tk_chan.steps = sc_chan.seq_len;
                            tk_chan.cyc   = sc_chan.cyc - 16'd1;
                            tk_iv         = mcppt_pkg::IV_A;
                            tk_chan.rem   = mcppt_pkg::sat_ticks(sc_chan.a);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcppt_pkg::BK_IDLE: begin
                if (i_cmd_valid && (i_cmd.op == mcppt_pkg::CMD_TICK)) begin
                    n_state = mcppt_pkg::BK_SCAN;
                end
            end
            mcppt_pkg::BK_SCAN: begin
                if (step && scan_last) begin
                    n_state = (r_hold_valid || keep) ? mcppt_pkg::BK_FLUSH : mcppt_pkg::BK_IDLE;
                end
            end
            mcppt_pkg::BK_FLUSH: begin
                if (out_free) begin
                    n_state = mcppt_pkg::BK_IDLE;
                end
            end
            default: n_state = mcppt_pkg::BK_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_cmd_pop    = 1'b0;
        out_load     = 1'b0;
        out_val      = '0;
        wr_iv_en     = 1'b0;
        wr_chan_en   = 1'b0;
        wr_idx       = r_scan;
        wr_iv        = tk_iv;
        wr_chan      = tk_chan;
        n_scan       = r_scan;
        n_hold_valid = r_hold_valid;
        n_hold_ch    = r_hold_ch;
        n_hold_pw    = r_hold_pw;
        n_nres       = r_nres;
        case (r_state)
            mcppt_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        mcppt_pkg::CMD_TICK: begin
                            o_cmd_pop    = 1'b1;
                            n_scan       = '0;
                            n_hold_valid = 1'b0;
                            n_nres       = '0;
                        end
                        mcppt_pkg::CMD_START: begin
                            if (out_free) begin
                                o_cmd_pop           = 1'b1;
                                out_load            = 1'b1;
                                out_val.kind        = i_cmd.ok ? mcppt_pkg::KIND_ACCEPTED
                                                               : mcppt_pkg::KIND_REJECTED;
                                out_val.out_channel = i_cmd.channel;
                                out_val.last        = 1'b1;
                                wr_iv_en            = i_cmd.ok;
                                wr_chan_en          = i_cmd.ok;
                                wr_idx              = cmd_idx;
                                wr_iv               = mcppt_pkg::IV_A;
                                wr_chan.rem         = mcppt_pkg::sat_ticks(i_cmd.a);
                                wr_chan.cyc         = i_cmd.cyc;
                                wr_chan.steps       = i_cmd.seq_len;
                                wr_chan.mode        = i_cmd.mode;
                                wr_chan.a           = i_cmd.a;
                                wr_chan.b           = i_cmd.b;
                                wr_chan.p           = i_cmd.p;
                                wr_chan.seq_len     = i_cmd.seq_len;
                            end
                        end
                        mcppt_pkg::CMD_STOP: begin
                            if (out_free) begin
                                o_cmd_pop           = 1'b1;
                                out_load            = 1'b1;
                                out_val.kind        = mcppt_pkg::KIND_STOP_DONE;
                                out_val.out_channel = i_cmd.channel;
                                out_val.last        = 1'b1;
                                wr_iv_en            = i_cmd.ok;
                                wr_idx              = cmd_idx;
                                wr_iv               = mcppt_pkg::IV_IDLE;
                            end
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            mcppt_pkg::BK_SCAN: begin
                if (step) begin
                    wr_iv_en   = 1'b1;
                    wr_chan_en = 1'b1;
                    if (need_out) begin
                        out_load            = 1'b1;
                        out_val.kind        = mcppt_pkg::KIND_DRIVE;
                        out_val.out_channel = r_hold_ch;
                        out_val.powered     = r_hold_pw;
                        out_val.last        = 1'b0;
                    end
                    if (keep) begin
                        n_hold_valid = 1'b1;
                        n_hold_ch    = 2'(r_scan);
                        n_hold_pw    = tk_pw;
                        n_nres       = r_nres + mcppt_pkg::NRES_BITS'(1);
                    end
                    if (!scan_last) begin
                        n_scan = r_scan + mcppt_pkg::CH_BITS'(1);
                    end
                end
            end
            mcppt_pkg::BK_FLUSH: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_val.kind        = mcppt_pkg::KIND_DRIVE;
                    out_val.out_channel = r_hold_ch;
                    out_val.powered     = r_hold_pw;
                    out_val.last        = 1'b1;
                    n_hold_valid        = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_chan_en) begin
            r_chan[wr_idx] <= wr_chan;
        end
        if (out_load) begin
            r_out <= out_val;
        end
        r_hold_ch <= n_hold_ch;
        r_hold_pw <= n_hold_pw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mcppt_pkg::BK_IDLE;
            r_scan       <= '0;
            r_hold_valid <= 1'b0;
            r_nres       <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < mcppt_pkg::CHANNELS; i++) begin
                r_iv[i] <= mcppt_pkg::IV_IDLE;
            end
        end else begin
            r_state      <= n_state;
            r_scan       <= n_scan;
            r_hold_valid <= n_hold_valid;
            r_nres       <= n_nres;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_iv_en) begin
                r_iv[wr_idx] <= wr_iv;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/multi_channel_pulse_pattern_timer.sv
// Four-channel pulse pattern timer. Each channel runs one-shot, PWM or
// sequence patterns counted in ticks; a start beat validates and loads a
// channel, a stop beat clears it, and a tick beat counts down every armed
// channel and emits at most one drive result per expiry, in channel order.
// Input beats are accepted every cycle while the two-entry command queue
// has room. The execution side handles a start or stop straight from its
// idle state, and a tick by a queue pop and then a walk of one channel per
// cycle unless a drive result waits for the output register, plus a flush
// of the final drive result when the tick produced any; this walk over the
// channel state is what sets the tick rate. Results leave through an
// output register backed by a one-entry hold slot: a tick starts its walk
// while an earlier result still waits to be taken, but a start or stop, a
// tick's second drive result and the final flush each wait until that
// register is free, so a stalled receiver holds all of these back.
// Configuration writes take effect at the next accepted beat.
module multi_channel_pulse_pattern_timer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [mcppt_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    // input beats
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mcppt_pkg::t_in                      i_in_data,
    // result beats
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mcppt_pkg::t_out                     o_out_data
);

    // front to queue
    logic            q_full;
    logic            q_push;
    mcppt_pkg::t_cmd q_in_cmd;

    // queue to back
    logic            q_valid;
    logic            q_pop;
    mcppt_pkg::t_cmd q_head;

    // Classify each beat, check start parameters against the limits and
    // clamp enabled intervals; drop unknown operations here.
    mcppt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in_cmd)
    );

    // Hold classified commands so the front keeps accepting while the back
    // walks the channels on a tick.
    mcppt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_head),
        .i_pop   (q_pop)
    );

    // Own the channel state; execute start, stop and tick commands and
    // drive the output register.
    mcppt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
